// ===== rtl/core/tld_pkg.sv =====
// ----------------------------------------------------------------------------
// tld_pkg
// shared types, widths and weight decode for the ternary dot product
// ----------------------------------------------------------------------------
package tld_pkg;

    localparam int ACC_WIDTH_DEF = 32;
    localparam int ACT_W         = 8;
    localparam int CODE_W        = 4;
    localparam int LANES         = 4;
    localparam int PAIR_W        = ACT_W + 2;
    localparam int ITEM_W        = PAIR_W + 2;
    localparam int OUT_W         = 32;

    typedef enum logic [1:0] {
        W_NEG  = 2'd0,
        W_ZERO = 2'd1,
        W_POS  = 2'd2
    } weight_t;

    typedef struct packed {
        weight_t even_w;
        weight_t odd_w;
    } pair_wt_t;

    typedef logic signed [PAIR_W-1:0] pair_sum_t;

    typedef struct packed {
        logic valid;
        logic last;
    } stage_ctrl_t;

    // even weight = code/3 - 1, odd weight = code%3 - 1, unused codes add zero
    function automatic pair_wt_t decode_code(input logic [CODE_W-1:0] code);
        pair_wt_t w;
        case (code)
            4'd0:    w = '{even_w: W_NEG,  odd_w: W_NEG};
            4'd1:    w = '{even_w: W_NEG,  odd_w: W_ZERO};
            4'd2:    w = '{even_w: W_NEG,  odd_w: W_POS};
            4'd3:    w = '{even_w: W_ZERO, odd_w: W_NEG};
            4'd4:    w = '{even_w: W_ZERO, odd_w: W_ZERO};
            4'd5:    w = '{even_w: W_ZERO, odd_w: W_POS};
            4'd6:    w = '{even_w: W_POS,  odd_w: W_NEG};
            4'd7:    w = '{even_w: W_POS,  odd_w: W_ZERO};
            4'd8:    w = '{even_w: W_POS,  odd_w: W_POS};
            default: w = '{even_w: W_ZERO, odd_w: W_ZERO};
        endcase
        return w;
    endfunction

    function automatic pair_sum_t apply_weight(input weight_t w,
                                               input logic signed [ACT_W-1:0] a);
        pair_sum_t ext;
        pair_sum_t r;
        ext = pair_sum_t'(a);
        case (w)
            W_NEG:   r = -ext;
            W_POS:   r = ext;
            default: r = '0;
        endcase
        return r;
    endfunction

endpackage

// ===== rtl/core/ternary_lut_dot_product.sv =====
// ----------------------------------------------------------------------------
// ternary_lut_dot_product
// dot product of signed 8-bit activations with packed ternary weight codes
// ----------------------------------------------------------------------------
// channel   direction  payload
// s_        in         two weight bytes, eight activations, last_item
// m_        out        dot_total, one per request with last_item set
//
// one request per cycle unless m_ stalls a last request; four pair lanes
// feed a stage register, the merge stage sums and accumulates in the same cycle
// an accepted last request passes the stage register, then out_reg and m_valid
// a stall on m_ holds the stage only when it carries a last request
// synchronous active-low reset clears the accumulator and valid flags
// ----------------------------------------------------------------------------
module ternary_lut_dot_product #(
    parameter int ACC_WIDTH = tld_pkg::ACC_WIDTH_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [7:0]                        s_weight_byte_first,
    input  logic [7:0]                        s_weight_byte_second,
    input  logic signed [tld_pkg::ACT_W-1:0]  s_activation_0,
    input  logic signed [tld_pkg::ACT_W-1:0]  s_activation_1,
    input  logic signed [tld_pkg::ACT_W-1:0]  s_activation_2,
    input  logic signed [tld_pkg::ACT_W-1:0]  s_activation_3,
    input  logic signed [tld_pkg::ACT_W-1:0]  s_activation_4,
    input  logic signed [tld_pkg::ACT_W-1:0]  s_activation_5,
    input  logic signed [tld_pkg::ACT_W-1:0]  s_activation_6,
    input  logic signed [tld_pkg::ACT_W-1:0]  s_activation_7,
    input  logic                              s_last_item,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic signed [tld_pkg::OUT_W-1:0]  m_dot_total
);

    logic [tld_pkg::CODE_W-1:0]       codes    [tld_pkg::LANES];
    logic signed [tld_pkg::ACT_W-1:0] act_even [tld_pkg::LANES];
    logic signed [tld_pkg::ACT_W-1:0] act_odd  [tld_pkg::LANES];
    tld_pkg::pair_sum_t               lane_out [tld_pkg::LANES];
    tld_pkg::pair_sum_t               lane_reg [tld_pkg::LANES];

    tld_pkg::stage_ctrl_t s1_reg, s1_next;
    logic                 advance;

    // high nibble first
    assign codes[0]    = s_weight_byte_first[7:4];
    assign codes[1]    = s_weight_byte_first[3:0];
    assign codes[2]    = s_weight_byte_second[7:4];
    assign codes[3]    = s_weight_byte_second[3:0];
    assign act_even[0] = s_activation_0;
    assign act_odd[0]  = s_activation_1;
    assign act_even[1] = s_activation_2;
    assign act_odd[1]  = s_activation_3;
    assign act_even[2] = s_activation_4;
    assign act_odd[2]  = s_activation_5;
    assign act_even[3] = s_activation_6;
    assign act_odd[3]  = s_activation_7;

    generate
        for (genvar g = 0; g < tld_pkg::LANES; g++) begin : g_lane
            tld_lane u_lane (
                .code     (codes[g]),
                .act_even (act_even[g]),
                .act_odd  (act_odd[g]),
                .pair_sum (lane_out[g])
            );
        end
    endgenerate

    assign s_ready = !s1_reg.valid || advance;

    always_comb begin
        s1_next = s1_reg;
        if (s_ready) begin
            s1_next.valid = s_valid;
            s1_next.last  = s_last_item;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_reg <= '0;
        end else begin
            s1_reg <= s1_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            lane_reg <= lane_out;
        end
    end

    tld_acc #(
        .ACC_WIDTH (ACC_WIDTH)
    ) u_acc (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s1_ctrl     (s1_reg),
        .lane_sum    (lane_reg),
        .advance     (advance),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_dot_total (m_dot_total)
    );

endmodule

// ===== rtl/core/tld_lane.sv =====
// ----------------------------------------------------------------------------
// tld_lane
// one activation pair: decode the 4-bit code and form the weighted pair sum
// ----------------------------------------------------------------------------
module tld_lane (
    input  logic [tld_pkg::CODE_W-1:0]       code,
    input  logic signed [tld_pkg::ACT_W-1:0] act_even,
    input  logic signed [tld_pkg::ACT_W-1:0] act_odd,
    output tld_pkg::pair_sum_t               pair_sum
);

    tld_pkg::pair_wt_t wt;

    always_comb begin
        wt       = tld_pkg::decode_code(code);
        pair_sum = tld_pkg::apply_weight(wt.even_w, act_even)
                 + tld_pkg::apply_weight(wt.odd_w, act_odd);
    end

endmodule

// ===== rtl/core/tld_acc.sv =====
// ----------------------------------------------------------------------------
// tld_acc
// merges the lane sums, accumulates and holds the result register
// ----------------------------------------------------------------------------
module tld_acc #(
    parameter int ACC_WIDTH = tld_pkg::ACC_WIDTH_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  tld_pkg::stage_ctrl_t              s1_ctrl,
    input  tld_pkg::pair_sum_t                lane_sum [tld_pkg::LANES],
    output logic                              advance,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic signed [tld_pkg::OUT_W-1:0]  m_dot_total
);

    logic signed [tld_pkg::ITEM_W-1:0] item_sum;
    logic [ACC_WIDTH-1:0]              acc_sum;
    logic [ACC_WIDTH-1:0]              acc_reg, acc_next;
    logic [ACC_WIDTH-1:0]              out_reg, out_next;
    logic                              m_valid_reg, m_valid_next;

    always_comb begin
        item_sum = '0;
        for (int i = 0; i < tld_pkg::LANES; i++) begin
            item_sum = item_sum + tld_pkg::ITEM_W'(lane_sum[i]);
        end
        acc_sum = acc_reg + {{(ACC_WIDTH-tld_pkg::ITEM_W){item_sum[tld_pkg::ITEM_W-1]}},
                             item_sum};
    end

    always_comb begin
        advance      = s1_ctrl.valid && (!s1_ctrl.last || !m_valid_reg || m_ready);
        acc_next     = acc_reg;
        out_next     = out_reg;
        m_valid_next = m_valid_reg && !m_ready;
        if (advance) begin
            if (s1_ctrl.last) begin
                acc_next     = '0;
                out_next     = acc_sum;
                m_valid_next = 1'b1;
            end else begin
                acc_next = acc_sum;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            acc_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            acc_reg     <= acc_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_reg <= out_next;
    end

    assign m_valid = m_valid_reg;

    generate
        if (ACC_WIDTH >= tld_pkg::OUT_W) begin : g_trunc
            assign m_dot_total = out_reg[tld_pkg::OUT_W-1:0];
        end else begin : g_sext
            assign m_dot_total = {{(tld_pkg::OUT_W-ACC_WIDTH){out_reg[ACC_WIDTH-1]}},
                                  out_reg};
        end
    endgenerate

endmodule

// ===== bench/tb_ternary_lut_dot_product.sv =====
// ----------------------------------------------------------------------------
// tb_ternary_lut_dot_product
// self-checking bench for the ternary weight dot product: directed requests
// walk every weight code and the activation extremes, then random vectors of
// mixed length run under four sender/receiver idle mixes; a scoreboard keeps
// its own running sum and compares every emitted total in order
// ----------------------------------------------------------------------------
class dot_scoreboard;
    localparam int ACC_W          = tld_pkg::ACC_WIDTH_DEF;
    localparam int FIRST_DEAD_CODE = 9;

    logic signed [ACC_W-1:0] running_sum;
    logic signed [31:0]      totals_q[$];
    int                      errors;
    int                      requests;
    int                      totals_seen;

    function new();
        running_sum = '0;
        errors      = 0;
        requests    = 0;
        totals_seen = 0;
    endfunction

    function int pair_term(logic [3:0] code, logic signed [7:0] ev, logic signed [7:0] od);
        int ew;
        int ow;
        if (code >= FIRST_DEAD_CODE) return 0;
        ew = int'(code / 4'd3) - 1;
        ow = int'(code % 4'd3) - 1;
        return ew * ev + ow * od;
    endfunction

    function void note_request(logic [7:0] wb0, logic [7:0] wb1, logic [63:0] acts,
                               logic last);
        logic [15:0] codes;
        int          item_sum;
        codes    = {wb0, wb1};
        item_sum = 0;
        for (int p = 0; p < 4; p++) begin
            item_sum += pair_term(codes[15-4*p -: 4], acts[16*p +: 8], acts[16*p+8 +: 8]);
        end
        running_sum = running_sum + ACC_W'(item_sum);
        requests++;
        if (last) begin
            totals_q.push_back(32'(running_sum));
            running_sum = '0;
        end
    endfunction

    function void check_total(logic signed [31:0] got);
        logic signed [31:0] want;
        if (totals_q.size() == 0) begin
            $error("dot_total: no total expected, got %0d", got);
            errors++;
            return;
        end
        want = totals_q.pop_front();
        totals_seen++;
        if (got !== want) begin
            $error("dot_total mismatch: expected %0d, got %0d", want, got);
            errors++;
        end
    endfunction

    function int pending();
        return totals_q.size();
    endfunction
endclass

module tb_ternary_lut_dot_product;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int DRAIN_CYCLES = 10;
    localparam int PHASE_ITEMS  = 120;

    logic               aclk = 1'b0;
    logic               aresetn;
    logic               s_valid;
    logic               s_ready;
    logic [7:0]         s_weight_byte_first;
    logic [7:0]         s_weight_byte_second;
    logic signed [7:0]  s_activation_0;
    logic signed [7:0]  s_activation_1;
    logic signed [7:0]  s_activation_2;
    logic signed [7:0]  s_activation_3;
    logic signed [7:0]  s_activation_4;
    logic signed [7:0]  s_activation_5;
    logic signed [7:0]  s_activation_6;
    logic signed [7:0]  s_activation_7;
    logic               s_last_item;
    logic               m_valid;
    logic               m_ready = 1'b0;
    logic signed [31:0] m_dot_total;

    int src_idle_pct;
    int sink_stall_pct;
    int cycles = 0;
    int vectors_sent;

    dot_scoreboard sb = new();

    ternary_lut_dot_product dut (
        .aclk                 (aclk),
        .aresetn              (aresetn),
        .s_valid              (s_valid),
        .s_ready              (s_ready),
        .s_weight_byte_first  (s_weight_byte_first),
        .s_weight_byte_second (s_weight_byte_second),
        .s_activation_0       (s_activation_0),
        .s_activation_1       (s_activation_1),
        .s_activation_2       (s_activation_2),
        .s_activation_3       (s_activation_3),
        .s_activation_4       (s_activation_4),
        .s_activation_5       (s_activation_5),
        .s_activation_6       (s_activation_6),
        .s_activation_7       (s_activation_7),
        .s_last_item          (s_last_item),
        .m_valid              (m_valid),
        .m_ready              (m_ready),
        .m_dot_total          (m_dot_total)
    );

    always #5 aclk = ~aclk;

    always @(posedge aclk) begin
        m_ready <= ($urandom_range(0, 99) >= sink_stall_pct);
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready) begin
                sb.note_request(s_weight_byte_first, s_weight_byte_second,
                                {s_activation_7, s_activation_6, s_activation_5,
                                 s_activation_4, s_activation_3, s_activation_2,
                                 s_activation_1, s_activation_0},
                                s_last_item);
            end
            if (m_valid && m_ready) begin
                sb.check_total(m_dot_total);
            end
        end
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("ternary_lut_dot_product verification failed");
            $finish;
        end
    end

    function automatic logic [3:0] rand_code();
        if ($urandom_range(0, 99) < 80) return 4'($urandom_range(0, 8));
        return 4'($urandom_range(9, 15));
    endfunction

    function automatic logic [7:0] rand_activation();
        case ($urandom_range(0, 9))
            0:       return 8'h80;
            1:       return 8'h7f;
            default: return 8'($urandom);
        endcase
    endfunction

    task automatic send_request(input logic [7:0] wb0, input logic [7:0] wb1,
                                input logic [63:0] acts, input logic last);
        while ($urandom_range(0, 99) < src_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid              <= 1'b1;
        s_weight_byte_first  <= wb0;
        s_weight_byte_second <= wb1;
        s_activation_0       <= acts[7:0];
        s_activation_1       <= acts[15:8];
        s_activation_2       <= acts[23:16];
        s_activation_3       <= acts[31:24];
        s_activation_4       <= acts[39:32];
        s_activation_5       <= acts[47:40];
        s_activation_6       <= acts[55:48];
        s_activation_7       <= acts[63:56];
        s_last_item          <= last;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    task automatic send_vector(input int len);
        logic [63:0] acts;
        for (int i = 0; i < len; i++) begin
            for (int a = 0; a < 8; a++) acts[8*a +: 8] = rand_activation();
            send_request({rand_code(), rand_code()}, {rand_code(), rand_code()}, acts,
                         i == len - 1);
        end
        vectors_sent++;
    endtask

    // drop s_valid and let the last accepted request be noted before waiting on the scoreboard
    task automatic wait_drained();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (sb.pending() != 0) @(posedge aclk);
    endtask

    task automatic run_phase(input int idle_pct, input int stall_pct);
        int sent;
        int len;
        sent           = 0;
        src_idle_pct   = idle_pct;
        sink_stall_pct = stall_pct;
        while (sent < PHASE_ITEMS) begin
            case ($urandom_range(0, 19))
                0:       len = $urandom_range(30, 60);
                1, 2, 3: len = $urandom_range(7, 20);
                default: len = $urandom_range(1, 6);
            endcase
            send_vector(len);
            sent += len;
        end
        wait_drained();
    endtask

    initial begin
        logic [7:0] c;
        aresetn              <= 1'b0;
        s_valid              <= 1'b0;
        s_weight_byte_first  <= '0;
        s_weight_byte_second <= '0;
        s_activation_0       <= '0;
        s_activation_1       <= '0;
        s_activation_2       <= '0;
        s_activation_3       <= '0;
        s_activation_4       <= '0;
        s_activation_5       <= '0;
        s_activation_6       <= '0;
        s_activation_7       <= '0;
        s_last_item          <= 1'b0;
        vectors_sent          = 0;
        src_idle_pct          = 0;
        sink_stall_pct        = 0;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // each code once per pattern, extremes on both members of every pair
        for (int k = 0; k < 4; k++) begin
            c = 8'(4 * k);
            send_request({c[3:0], 4'(c + 1)}, {4'(c + 2), 4'(c + 3)}, {8{8'h80}}, 1'b0);
        end
        send_request(8'h88, 8'h88, {8{8'h80}}, 1'b1);
        for (int k = 0; k < 4; k++) begin
            c = 8'(4 * k);
            send_request({c[3:0], 4'(c + 1)}, {4'(c + 2), 4'(c + 3)}, {8{8'h7f}}, 1'b1);
        end
        for (int k = 0; k < 4; k++) begin
            c = 8'(4 * k);
            send_request({c[3:0], 4'(c + 1)}, {4'(c + 2), 4'(c + 3)},
                         64'h807f_807f_807f_807f, k == 3);
        end
        send_request(8'h00, 8'h00, {8{8'h80}}, 1'b1);
        send_request(8'h88, 8'h88, {8{8'h7f}}, 1'b1);
        send_request(8'hff, 8'h9a, {8{8'h7f}}, 1'b1);
        send_request(8'h26, 8'h62, 64'h7f80_7f80_7f80_7f80, 1'b0);
        send_request(8'h26, 8'h62, 64'h807f_807f_807f_807f, 1'b1);
        wait_drained();

        run_phase(0, 0);
        run_phase(77, 0);
        run_phase(0, 77);
        run_phase(31, 31);

        repeat (DRAIN_CYCLES) @(posedge aclk);
        $display("run covered %0d requests in %0d vectors", sb.requests, vectors_sent + 10);
        $display("%0d totals compared under four idle and stall mixes", sb.totals_seen);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("ternary_lut_dot_product verification clean");
        end else begin
            $display("ternary_lut_dot_product verification failed");
        end
        $finish;
    end
endmodule

// ===== files.f =====
rtl/core/tld_pkg.sv
rtl/core/tld_lane.sv
rtl/core/tld_acc.sv
rtl/core/ternary_lut_dot_product.sv
bench/tb_ternary_lut_dot_product.sv
